// ----- hdl/five_stage_mips_pipeline_assert.svh -----
`ifndef FIVE_STAGE_MIPS_PIPELINE_ASSERT_SVH
`define FIVE_STAGE_MIPS_PIPELINE_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define MIPS5_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mips5 check failed");
// Next-cycle implication, checked outside reset.
`define MIPS5_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mips5 check failed");
`endif

// ----- hdl/mips5_pkg.sv -----
package mips5_pkg;

  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_STEP  = 3'd1;
  localparam logic [2:0] REQ_RREG  = 3'd2;
  localparam logic [2:0] REQ_WDATA = 3'd3;
  localparam logic [2:0] REQ_RDATA = 3'd4;

  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_SLT  = 4'd4;
  localparam logic [3:0] OP_ADDI = 4'd5;
  localparam logic [3:0] OP_LW   = 4'd6;
  localparam logic [3:0] OP_SW   = 4'd7;
  localparam logic [3:0] OP_BEQ  = 4'd8;
  localparam logic [3:0] OP_BNE  = 4'd9;
  localparam logic [3:0] OP_J    = 4'd10;
  localparam logic [3:0] OP_JAL  = 4'd11;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [9:0]         address;
    logic [3:0]         opcode;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_s;
    logic [4:0]         src_reg_t;
    logic signed [31:0] immediate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         fetch_pc;
    logic               wb_valid;
    logic [4:0]         wb_reg;
    logic signed [31:0] wb_value;
    logic               store_valid;
    logic [9:0]         store_addr;
    logic signed [31:0] store_value;
  } out_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [31:0] imm;
  } instr_t;

endpackage

// ----- hdl/mips5_ram.sv -----
module mips5_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hdl/mips5_core.sv -----
module mips5_core import mips5_pkg::*; #(
  parameter int IMEM_DEPTH = 256,
  parameter int DMEM_DEPTH = 1024,
  parameter int NUM_REGS   = 32,
  localparam int PCW = $clog2(IMEM_DEPTH),
  localparam int ADW = $clog2(DMEM_DEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  in_t            item,
  input  instr_t         imem_rdata,
  input  logic [31:0]    dmem_rdata,
  output logic           imem_en,
  output logic           imem_we,
  output logic [PCW-1:0] imem_addr,
  output instr_t         imem_wdata,
  output logic           dmem_en,
  output logic           dmem_we,
  output logic [ADW-1:0] dmem_addr,
  output logic [31:0]    dmem_wdata,
  output out_t           res,
  output logic           res_mem
);

  localparam int RW = $clog2(NUM_REGS);

  typedef struct packed {
    logic [3:0]     op;
    logic [4:0]     dst;
    logic [31:0]    a;
    logic [31:0]    b;
    logic [31:0]    imm;
    logic [PCW-1:0] pc;
  } de_t;

  typedef struct packed {
    logic [3:0]     op;
    logic [4:0]     dst;
    logic [31:0]    ar;
    logic [31:0]    b;
    logic [PCW-1:0] target;
    logic           z;
  } em_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  dst;
    logic [31:0] val;
  } mw_t;

  logic [PCW-1:0] pc_r, pc1, pc2, pc_nxt;
  logic           fd_valid_r;
  logic [PCW-1:0] fd_pc_r;
  de_t            de_r, de_nxt;
  em_t            em_r, em_nxt;
  mw_t            mw_r, mw_nxt;
  logic           mw_pend_r;
  logic [31:0]    rf_r [NUM_REGS];
  instr_t         fd_ins;
  logic           step, wb_en, link_en;
  logic [31:0]    wb_val, link_val, rs_val, rt_val;

  assign step    = go && (item.req_type == REQ_STEP);
  assign fd_ins  = fd_valid_r ? imem_rdata : '0;
  assign wb_en   = (mw_r.op >= OP_ADD) && (mw_r.op <= OP_LW);
  assign wb_val  = mw_pend_r ? dmem_rdata : mw_r.val;

  // memory stage
  always_comb begin
    mw_nxt     = '0;
    mw_nxt.op  = em_r.op;
    mw_nxt.dst = em_r.dst;
    pc1        = pc_r;
    unique case (em_r.op)
      OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI: mw_nxt.val = em_r.ar;
      OP_BEQ: if (em_r.z) pc1 = em_r.target;
      OP_BNE: if (!em_r.z) pc1 = em_r.target;
      default: ;
    endcase
  end

  // execute stage
  always_comb begin
    em_nxt     = '0;
    em_nxt.op  = de_r.op;
    em_nxt.dst = de_r.dst;
    pc2        = pc1;
    link_en    = 1'b0;
    unique case (de_r.op)
      OP_ADD:  em_nxt.ar = de_r.a + de_r.b;
      OP_SUB:  em_nxt.ar = de_r.a - de_r.b;
      OP_MUL:  em_nxt.ar = de_r.a * de_r.b;
      OP_SLT:  em_nxt.ar = {31'd0, $signed(de_r.a) < $signed(de_r.b)};
      OP_ADDI, OP_LW: em_nxt.ar = de_r.a + de_r.imm;
      OP_SW: begin
        em_nxt.ar = de_r.a + de_r.imm;
        em_nxt.b  = de_r.b;
      end
      OP_BEQ, OP_BNE: begin
        em_nxt.target = de_r.pc + de_r.imm[PCW-1:0];
        em_nxt.z      = (de_r.a == de_r.b);
      end
      OP_J: pc2 = de_r.imm[PCW-1:0];
      OP_JAL: begin
        link_en = 1'b1;
        pc2     = de_r.imm[PCW-1:0];
      end
      default: ;
    endcase
  end

  assign link_val = 32'(pc1);

  // decode sees write-back and the link write of this step
  always_comb begin
    priority if (link_en && fd_ins.rs == LINK_REG) rs_val = link_val;
    else if (wb_en && fd_ins.rs == mw_r.dst) rs_val = wb_val;
    else rs_val = rf_r[fd_ins.rs[RW-1:0]];
    priority if (link_en && fd_ins.rt == LINK_REG) rt_val = link_val;
    else if (wb_en && fd_ins.rt == mw_r.dst) rt_val = wb_val;
    else rt_val = rf_r[fd_ins.rt[RW-1:0]];
    de_nxt.op  = fd_ins.op;
    de_nxt.dst = fd_ins.rd;
    de_nxt.a   = rs_val;
    de_nxt.b   = rt_val;
    de_nxt.imm = fd_ins.imm;
    de_nxt.pc  = fd_pc_r;
  end

  assign pc_nxt = pc2 + 1'b1;

  // store ports
  always_comb begin
    imem_en          = 1'b0;
    imem_we          = 1'b0;
    imem_addr        = PCW'(item.address);
    imem_wdata       = '0;
    imem_wdata.op    = (item.opcode > OP_JAL) ? OP_NOP : item.opcode;
    imem_wdata.rd    = item.dest_reg;
    imem_wdata.rs    = item.src_reg_s;
    imem_wdata.rt    = item.src_reg_t;
    imem_wdata.imm   = item.immediate;
    dmem_en          = 1'b0;
    dmem_we          = 1'b0;
    dmem_addr        = ADW'(item.address);
    dmem_wdata       = item.immediate;
    if (go) begin
      unique case (item.req_type)
        REQ_LOAD: begin
          imem_en = 1'b1;
          imem_we = 1'b1;
        end
        REQ_STEP: begin
          imem_en   = 1'b1;
          imem_addr = pc2;
          dmem_addr = em_r.ar[ADW-1:0];
          dmem_wdata = em_r.b;
          dmem_en   = (em_r.op == OP_LW) || (em_r.op == OP_SW);
          dmem_we   = (em_r.op == OP_SW);
        end
        REQ_WDATA: begin
          dmem_en = 1'b1;
          dmem_we = 1'b1;
        end
        REQ_RDATA: dmem_en = 1'b1;
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    res      = '0;
    res_mem  = go && (item.req_type == REQ_RDATA);
    res.fetch_pc = 8'(pc_r);
    if (step) begin
      res.fetch_pc = 8'(pc_nxt);
      if (wb_en) begin
        res.wb_valid = 1'b1;
        res.wb_reg   = mw_r.dst;
        res.wb_value = wb_val;
      end
      if (em_r.op == OP_SW) begin
        res.store_valid = 1'b1;
        res.store_addr  = 10'(em_r.ar[ADW-1:0]);
        res.store_value = em_r.b;
      end
    end
    if (go && item.req_type == REQ_RREG) begin
      res.read_value = rf_r[item.address[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= '0;
      fd_valid_r <= 1'b0;
      fd_pc_r    <= '0;
      de_r       <= '0;
      em_r       <= '0;
      mw_r       <= '0;
      mw_pend_r  <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
    end else begin
      if (step) begin
        // the link write wins over a write-back to the same register
        if (wb_en && !(link_en && mw_r.dst == LINK_REG)) rf_r[mw_r.dst[RW-1:0]] <= wb_val;
        if (link_en) rf_r[LINK_REG[RW-1:0]] <= link_val;
        mw_r       <= mw_nxt;
        mw_pend_r  <= (em_r.op == OP_LW);
        em_r       <= em_nxt;
        de_r       <= de_nxt;
        fd_valid_r <= 1'b1;
        fd_pc_r    <= pc_nxt;
        pc_r       <= pc_nxt;
      end else if (mw_pend_r) begin
        // capture the loaded word from the read port unless a step uses it first
        mw_r.val  <= dmem_rdata;
        mw_pend_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/five_stage_mips_pipeline.sv -----
// Result: registered as the request is taken; a data-word read is served
// from the data store's registered read port in that same result cycle.
// Throughput: one request per cycle while the result slot is free or being
// emptied; a step advances all five stages once. Reset: synchronous, active
// low; a clearing pass then zeroes both stores and no request is taken.
module five_stage_mips_pipeline import mips5_pkg::*; #(
  parameter int IMEM_DEPTH = 256,
  parameter int DMEM_DEPTH = 1024,
  parameter int NUM_REGS   = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // The user must keep store depths powers of two; the block does not enforce it. Addresses wrap by dropping high bits.
  localparam int PCW  = $clog2(IMEM_DEPTH);
  localparam int ADW  = $clog2(DMEM_DEPTH);
  localparam int CLRD = (IMEM_DEPTH > DMEM_DEPTH) ? IMEM_DEPTH : DMEM_DEPTH;
  localparam int CW   = $clog2(CLRD);

  logic           go;
  logic           busy_r;
  logic [CW-1:0]  clr_r;
  logic           out_valid_r, res_mem_r;
  out_t           res_r, res;
  logic           res_mem;

  logic           c_imem_en, c_imem_we, c_dmem_en, c_dmem_we;
  logic [PCW-1:0] c_imem_addr;
  logic [ADW-1:0] c_dmem_addr;
  instr_t         c_imem_wdata, imem_rdata;
  logic [31:0]    c_dmem_wdata, dmem_rdata;

  logic           imem_en, imem_we, dmem_en, dmem_we;
  logic [PCW-1:0] imem_addr;
  logic [ADW-1:0] dmem_addr;
  instr_t         imem_wdata;
  logic [31:0]    dmem_wdata;

  // Take a request while the result slot is free or being emptied and no clearing pass runs.
  assign in_ready = !busy_r && (!out_valid_r || out_ready);
  assign go       = in_valid && in_ready;

  mips5_core #(
    .IMEM_DEPTH (IMEM_DEPTH),
    .DMEM_DEPTH (DMEM_DEPTH),
    .NUM_REGS   (NUM_REGS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .item       (in_data),
    .imem_rdata (imem_rdata),
    .dmem_rdata (dmem_rdata),
    .imem_en    (c_imem_en),
    .imem_we    (c_imem_we),
    .imem_addr  (c_imem_addr),
    .imem_wdata (c_imem_wdata),
    .dmem_en    (c_dmem_en),
    .dmem_we    (c_dmem_we),
    .dmem_addr  (c_dmem_addr),
    .dmem_wdata (c_dmem_wdata),
    .res        (res),
    .res_mem    (res_mem)
  );

  // Clearing pass owns both store ports after reset.
  always_comb begin
    if (busy_r) begin
      imem_en    = ({1'b0, clr_r} < (CW+1)'(IMEM_DEPTH));
      imem_we    = 1'b1;
      imem_addr  = PCW'(clr_r);
      imem_wdata = '0;
      dmem_en    = ({1'b0, clr_r} < (CW+1)'(DMEM_DEPTH));
      dmem_we    = 1'b1;
      dmem_addr  = ADW'(clr_r);
      dmem_wdata = '0;
    end else begin
      imem_en    = c_imem_en;
      imem_we    = c_imem_we;
      imem_addr  = c_imem_addr;
      imem_wdata = c_imem_wdata;
      dmem_en    = c_dmem_en;
      dmem_we    = c_dmem_we;
      dmem_addr  = c_dmem_addr;
      dmem_wdata = c_dmem_wdata;
    end
  end

  mips5_ram #(.W($bits(instr_t)), .DEPTH(IMEM_DEPTH)) u_imem (
    .clk   (clk),
    .en    (imem_en),
    .we    (imem_we),
    .addr  (imem_addr),
    .wdata (imem_wdata),
    .rdata (imem_rdata)
  );

  mips5_ram #(.W(32), .DEPTH(DMEM_DEPTH)) u_dmem (
    .clk   (clk),
    .en    (dmem_en),
    .we    (dmem_we),
    .addr  (dmem_addr),
    .wdata (dmem_wdata),
    .rdata (dmem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == CW'(CLRD - 1)) busy_r <= 1'b0;
      end
      // advance the result slot; drop it once taken
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold until replaced by the next request.
  always_ff @(posedge clk) begin
    if (go) begin
      res_r     <= res;
      res_mem_r <= res_mem;
    end
  end

  // The data read port holds its word while the result waits.
  always_comb begin
    out_data = res_r;
    if (res_mem_r) out_data.read_value = dmem_rdata;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/mips5_chk.sv -----
`include "five_stage_mips_pipeline_assert.svh"
module mips5_chk import mips5_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `MIPS5_AST_NOW(a_ready_free, in_ready, !out_valid || out_ready)
  `MIPS5_AST_NEXT(a_result_next, in_valid && in_ready, out_valid)
  `MIPS5_AST_NOW(a_wb_quiet, out_valid && !out_data.wb_valid, out_data.wb_reg == 5'd0)
  `MIPS5_AST_NEXT(a_out_held, out_valid && !out_ready, out_valid)

endmodule

bind five_stage_mips_pipeline mips5_chk u_chk (.*);
